// ===== sv/rafc_pkg.sv =====
package rafc_pkg;

    // Framing characters
    localparam logic [7:0] CH_STX = 8'h02;
    localparam logic [7:0] CH_ETX = 8'h03;
    localparam logic [7:0] CH_GT  = 8'h3E;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;

    // Byte positions within a 16-byte frame
    localparam logic [3:0] POS_START     = 4'd0;
    localparam logic [3:0] POS_TAG_FIRST = 4'd1;
    localparam logic [3:0] POS_TAG_LAST  = 4'd10;
    localparam logic [3:0] POS_CKS_FIRST = 4'd11;
    localparam logic [3:0] POS_CKS_LAST  = 4'd12;
    localparam logic [3:0] POS_CR        = 4'd13;
    localparam logic [3:0] POS_LF        = 4'd14;
    localparam logic [3:0] POS_END       = 4'd15;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_FIRST = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_LAST  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PORT_POS   = 2'd3;

    localparam logic [7:0] PORT_FIRST_RST = 8'd65;
    localparam logic [7:0] PORT_LAST_RST  = 8'd90;

    typedef struct packed {
        logic       concentrator_mode;
        logic [7:0] port_first;
        logic [7:0] port_last;
        logic [3:0] port_position;
    } t_cfg;

    typedef struct packed {
        logic        frame_valid;
        logic        checksum_ok;
        logic [39:0] tag_id;
        logic [7:0]  received_checksum;
        logic [7:0]  port_char;
        logic        init_message;
    } t_result;

    typedef struct packed {
        logic       bad;
        logic [3:0] value;
    } t_hex;

    // Decode one ASCII hex digit; anything else flags bad and reads as zero
    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex       h;
        logic [7:0] d;
        h = '0;
        d = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            d       = c - 8'h30;
            h.value = d[3:0];
        end else if (c >= 8'h41 && c <= 8'h46) begin
            d       = c - 8'h37;
            h.value = d[3:0];
        end else if (c >= 8'h61 && c <= 8'h66) begin
            d       = c - 8'h57;
            h.value = d[3:0];
        end else begin
            h.bad = 1'b1;
        end
        return h;
    endfunction

endpackage

// ===== sv/rafc_frame_track.sv =====
module rafc_frame_track (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  rafc_pkg::t_cfg    i_cfg,
    input  logic [7:0]        i_byte,
    input  logic              i_step,
    output logic              o_emit,
    output rafc_pkg::t_result o_result
);
    import rafc_pkg::*;

    logic [3:0]  r_byte_count, n_byte_count;
    logic [39:0] r_tag_shift, n_tag_shift;
    logic [7:0]  r_check_shift, n_check_shift;
    logic [7:0]  r_port_capture, n_port_capture;
    logic        r_start_ok, n_start_ok;
    logic        r_trailer_ok, n_trailer_ok;
    logic        r_hex_error, n_hex_error;

    logic        is_init;
    t_hex        hx;
    logic [7:0]  tag_xor;
    logic        cks;
    logic        head;
    logic        tail;

    assign is_init = (r_byte_count == POS_START) && i_cfg.concentrator_mode &&
                     (i_byte == CH_GT);
    assign hx = hex_decode(i_byte);

    // Updated frame state after taking this byte
    always_comb begin
        n_tag_shift    = r_tag_shift;
        n_check_shift  = r_check_shift;
        n_port_capture = r_port_capture;
        n_start_ok     = r_start_ok;
        n_trailer_ok   = r_trailer_ok;
        n_hex_error    = r_hex_error;
        n_byte_count   = r_byte_count + 4'd1;

        if (r_byte_count == POS_START) begin
            n_tag_shift    = '0;
            n_check_shift  = '0;
            n_port_capture = '0;
            n_trailer_ok   = 1'b0;
            n_hex_error    = 1'b0;
            n_start_ok     = (i_byte == CH_STX);
        end
        if (r_byte_count == i_cfg.port_position) begin
            n_port_capture = i_byte;
        end
        if (r_byte_count >= POS_TAG_FIRST && r_byte_count <= POS_TAG_LAST) begin
            n_tag_shift = {r_tag_shift[35:0], hx.value};
            n_hex_error = r_hex_error | hx.bad;
        end else if (r_byte_count >= POS_CKS_FIRST && r_byte_count <= POS_CKS_LAST) begin
            n_check_shift = {r_check_shift[3:0], hx.value};
            n_hex_error   = r_hex_error | hx.bad;
        end else if (r_byte_count == POS_CR) begin
            n_trailer_ok = (i_byte == CH_CR);
        end else if (r_byte_count == POS_LF) begin
            n_trailer_ok = r_trailer_ok & (i_byte == CH_LF);
        end
    end

    // Frame verdict, valid on the closing byte
    assign tag_xor = r_tag_shift[39:32] ^ r_tag_shift[31:24] ^ r_tag_shift[23:16] ^
                     r_tag_shift[15:8] ^ r_tag_shift[7:0];
    assign cks  = (tag_xor == r_check_shift) && !r_hex_error;
    assign head = i_cfg.concentrator_mode ?
                  ((n_port_capture >= i_cfg.port_first) &&
                   (n_port_capture <= i_cfg.port_last)) : r_start_ok;
    assign tail = i_cfg.concentrator_mode ? (i_byte == CH_GT) : (i_byte == CH_ETX);

    assign o_emit = is_init || (r_byte_count == POS_END);

    always_comb begin
        o_result = '0;
        if (is_init) begin
            o_result.init_message = 1'b1;
        end else begin
            o_result.frame_valid       = head & tail & r_trailer_ok & cks;
            o_result.checksum_ok       = cks;
            o_result.tag_id            = r_tag_shift;
            o_result.received_checksum = r_check_shift;
            o_result.port_char         = n_port_capture;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count   <= '0;
            r_tag_shift    <= '0;
            r_check_shift  <= '0;
            r_port_capture <= '0;
            r_start_ok     <= 1'b0;
            r_trailer_ok   <= 1'b0;
            r_hex_error    <= 1'b0;
        end else if (i_step && !is_init) begin
            r_byte_count   <= n_byte_count;
            r_tag_shift    <= n_tag_shift;
            r_check_shift  <= n_check_shift;
            r_port_capture <= n_port_capture;
            r_start_ok     <= n_start_ok;
            r_trailer_ok   <= n_trailer_ok;
            r_hex_error    <= n_hex_error;
        end
    end

endmodule

// ===== sv/rfid_ascii_frame_checker.sv =====
// Channel   Direction  Handshake                     Payload
// in        sink       i_in_valid / o_in_ready       i_rx_byte
// out       source     o_out_valid / i_out_ready     o_frame_valid .. o_init_message
// cfg       sink       i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// One byte per cycle sustained. A byte is held in the input register,
// then the frame tracker updates its state and, on the sixteenth byte or a
// concentrator init byte, loads the result register. Reset (synchronous, active
// low) clears the frame position, the tracker registers and both valid flags. A
// stalled result only holds back bytes that would produce a further result.
module rfid_ascii_frame_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [7:0]                       i_rx_byte,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic                             o_frame_valid,
    output logic                             o_checksum_ok,
    output logic [39:0]                      o_tag_id,
    output logic [7:0]                       o_received_checksum,
    output logic [7:0]                       o_port_char,
    output logic                             o_init_message,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rafc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [7:0]                       i_cfg_data
);
    import rafc_pkg::*;

    t_cfg       r_cfg;
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid, n_out_valid;
    t_result    r_out;

    logic       emit;
    logic       out_free;
    logic       step;
    t_result    result;

    // Configuration is always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.concentrator_mode <= 1'b0;
            r_cfg.port_first        <= PORT_FIRST_RST;
            r_cfg.port_last         <= PORT_LAST_RST;
            r_cfg.port_position     <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MODE:       r_cfg.concentrator_mode <= i_cfg_data[0];
                CFG_PORT_FIRST: r_cfg.port_first        <= i_cfg_data;
                CFG_PORT_LAST:  r_cfg.port_last         <= i_cfg_data;
                CFG_PORT_POS:   r_cfg.port_position     <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // Advance the held byte unless it has a result and the result slot is full
    assign out_free   = !r_out_valid || i_out_ready;
    assign step       = r_in_valid && (!emit || out_free);
    assign o_in_ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte <= i_rx_byte;
        end
    end

    rafc_frame_track u_track (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_byte   (r_in_byte),
        .i_step   (step),
        .o_emit   (emit),
        .o_result (result)
    );

    // Result register: load a new item, drop one once taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (step && emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && emit) begin
            r_out <= result;
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_frame_valid       = r_out.frame_valid;
    assign o_checksum_ok       = r_out.checksum_ok;
    assign o_tag_id            = r_out.tag_id;
    assign o_received_checksum = r_out.received_checksum;
    assign o_port_char         = r_out.port_char;
    assign o_init_message      = r_out.init_message;

endmodule
